[hdl/olt_pkg.sv]
// Package for the owned lock table: operation and result codes, queue sizing,
// and the control structs passed between the front, back and result queue.
// No dependencies.
package olt_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_REQUEST    = 2'd0;
    localparam logic [1:0] OP_RELEASE    = 2'd1;
    localparam logic [1:0] OP_INQUIRE    = 2'd2;
    localparam logic [1:0] OP_UNREGISTER = 2'd3;

    typedef logic [2:0] rc_t;

    localparam rc_t RC_GRANTED  = 3'd0;
    localparam rc_t RC_BUSY     = 3'd1;
    localparam rc_t RC_RELEASED = 3'd2;
    localparam rc_t RC_OWNED    = 3'd3;
    localparam rc_t RC_ADDED    = 3'd4;
    localparam rc_t RC_REMOVED  = 3'd5;
    localparam rc_t RC_DONE     = 3'd6;
    localparam rc_t RC_FULL     = 3'd7;

    // Two-entry queues on both sides of the back end.
    localparam int QDEPTH = 2;
    localparam int QCNT_W = 2;

    // Operation class decoded at the front, one-hot.
    typedef struct packed {
        logic req;
        logic rel;
        logic inq;
        logic unreg;
    } op_class_t;

    // Head of the item queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        op_class_t cls;
    } front_ctl_t;

    // Result write from the back end into the result queue.
    typedef struct packed {
        logic push;
        rc_t  code;
        logic last;
    } res_ctl_t;

endpackage

[hdl/olt_front.sv]
// Front end of the owned lock table: accepts items, decodes the opcode into
// an operation class and holds them in a two-entry queue for the back end.
// Depends on olt_pkg.
module olt_front #(
    parameter int KEY_BITS   = 32,
    parameter int OWNER_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic [KEY_BITS-1:0]     lock_key,
    input  logic [OWNER_BITS-1:0]   client_id,
    output olt_pkg::front_ctl_t     head_ctl,
    output logic [KEY_BITS-1:0]     head_key,
    output logic [OWNER_BITS-1:0]   head_cid,
    input  logic                    head_pop
);

    olt_pkg::op_class_t          cls_mem [olt_pkg::QDEPTH];
    logic [KEY_BITS-1:0]         key_mem [olt_pkg::QDEPTH];
    logic [OWNER_BITS-1:0]       cid_mem [olt_pkg::QDEPTH];

    logic [olt_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        wr_ptr_reg, rd_ptr_reg;
    logic                        push_ok, pop_ok;
    olt_pkg::op_class_t          cls_in;

    always_comb
    begin
        cls_in = '0;
        unique case (opcode)
            olt_pkg::OP_REQUEST:    cls_in.req   = 1'b1;
            olt_pkg::OP_RELEASE:    cls_in.rel   = 1'b1;
            olt_pkg::OP_INQUIRE:    cls_in.inq   = 1'b1;
            olt_pkg::OP_UNREGISTER: cls_in.unreg = 1'b1;
            default:                cls_in       = '0;
        endcase
    end

    assign full    = (count_reg == olt_pkg::QCNT_W'(olt_pkg::QDEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = head_pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (!push_ok && pop_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_ok)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            cls_mem[wr_ptr_reg] <= cls_in;
            key_mem[wr_ptr_reg] <= lock_key;
            cid_mem[wr_ptr_reg] <= client_id;
        end
    end

    assign head_ctl.valid = (count_reg != '0);
    assign head_ctl.cls   = cls_mem[rd_ptr_reg];
    assign head_key       = key_mem[rd_ptr_reg];
    assign head_cid       = cid_mem[rd_ptr_reg];

endmodule

[hdl/olt_back.sv]
// Back end of the owned lock table: the slot table with its parallel key
// match, and the sequencer that executes one item and writes its results.
// Depends on olt_pkg.
module olt_back #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int OWNER_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  olt_pkg::front_ctl_t     head_ctl,
    input  logic [KEY_BITS-1:0]     head_key,
    input  logic [OWNER_BITS-1:0]   head_cid,
    output logic                    head_pop,
    output olt_pkg::res_ctl_t       res_ctl,
    output logic [KEY_BITS-1:0]     res_key,
    output logic [OWNER_BITS-1:0]   res_owner,
    input  logic                    res_full
);

    localparam int WW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SECOND = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    // slot table
    logic [SLOTS-1:0]            valid_reg, valid_next;
    logic [KEY_BITS-1:0]         slot_key   [SLOTS];
    logic [OWNER_BITS-1:0]       slot_owner [SLOTS];

    // sequencer
    logic [2:0]                  st_reg, st_next;
    olt_pkg::op_class_t          cls_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [OWNER_BITS-1:0]       cid_reg;
    logic [SLOTS-1:0]            hit_reg;
    logic [SLOTS-1:0]            free_reg;
    logic                        own_reg;
    olt_pkg::rc_t                sec_reg, sec_next;
    logic [WW-1:0]               walk_reg, walk_next;

    logic [SLOTS-1:0]            match, owner_eq;
    logic                        alloc;
    logic                        walk_owned;
    logic                        walk_end;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i]    = valid_reg[i] && (slot_key[i] == head_key);
            owner_eq[i] = (slot_owner[i] == head_cid);
        end
    end

    assign walk_owned = valid_reg[walk_reg] && (slot_owner[walk_reg] == cid_reg);
    assign walk_end   = (walk_reg == WW'(SLOTS - 1));

    always_comb
    begin
        st_next        = st_reg;
        valid_next     = valid_reg;
        sec_next       = sec_reg;
        walk_next      = walk_reg;
        head_pop       = 1'b0;
        alloc          = 1'b0;
        res_ctl.push   = 1'b0;
        res_ctl.code   = olt_pkg::RC_BUSY;
        res_ctl.last   = 1'b1;
        res_key        = key_reg;
        res_owner      = cid_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (head_ctl.valid)
                begin
                    head_pop = 1'b1;
                    st_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cls_reg.unreg)
                begin
                    walk_next = '0;
                    st_next   = ST_WALK;
                end
                else if (!res_full)
                begin
                    res_ctl.push = 1'b1;
                    st_next      = ST_IDLE;
                    if (cls_reg.req)
                    begin
                        if (hit_reg != '0)
                            res_ctl.code = olt_pkg::RC_BUSY;
                        else if (free_reg == '0)
                            res_ctl.code = olt_pkg::RC_FULL;
                        else
                        begin
                            alloc        = 1'b1;
                            valid_next   = valid_reg | free_reg;
                            res_ctl.code = olt_pkg::RC_GRANTED;
                            res_ctl.last = 1'b0;
                            sec_next     = olt_pkg::RC_ADDED;
                            st_next      = ST_SECOND;
                        end
                    end
                    else if (cls_reg.rel)
                    begin
                        if (own_reg)
                        begin
                            valid_next   = valid_reg & ~hit_reg;
                            res_ctl.code = olt_pkg::RC_RELEASED;
                            res_ctl.last = 1'b0;
                            sec_next     = olt_pkg::RC_REMOVED;
                            st_next      = ST_SECOND;
                        end
                    end
                    else if (own_reg)
                        res_ctl.code = olt_pkg::RC_OWNED;
                end
            end
            ST_SECOND:
            begin
                if (!res_full)
                begin
                    res_ctl.push = 1'b1;
                    res_ctl.code = sec_reg;
                    st_next      = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                res_key = slot_key[walk_reg];
                if (!walk_owned || !res_full)
                begin
                    if (walk_owned)
                    begin
                        res_ctl.push         = 1'b1;
                        res_ctl.code         = olt_pkg::RC_REMOVED;
                        res_ctl.last         = 1'b0;
                        valid_next[walk_reg] = 1'b0;
                    end
                    if (walk_end)
                        st_next = ST_FIN;
                    else
                        walk_next = walk_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                res_key = '0;
                if (!res_full)
                begin
                    res_ctl.push = 1'b1;
                    res_ctl.code = olt_pkg::RC_DONE;
                    st_next      = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
        end
    end

    // item registers and lookup results, captured as the item is taken
    always_ff @(posedge clk)
    begin
        sec_reg  <= sec_next;
        walk_reg <= walk_next;
        if (head_pop)
        begin
            cls_reg  <= head_ctl.cls;
            key_reg  <= head_key;
            cid_reg  <= head_cid;
            hit_reg  <= match;
            own_reg  <= |(match & owner_eq);
            // lowest free slot, one-hot
            free_reg <= ~valid_reg & (valid_reg + SLOTS'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (alloc && free_reg[i])
            begin
                slot_key[i]   <= key_reg;
                slot_owner[i] <= cid_reg;
            end
        end
    end

endmodule

[hdl/olt_resq.sv]
// Result queue of the owned lock table: two entries between the back end
// and the result ports. Depends on olt_pkg.
module olt_resq #(
    parameter int KEY_BITS   = 32,
    parameter int OWNER_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  olt_pkg::res_ctl_t       res_ctl,
    input  logic [KEY_BITS-1:0]     res_key,
    input  logic [OWNER_BITS-1:0]   res_owner,
    output logic                    res_full,
    output logic                    empty,
    input  logic                    pop,
    output logic [2:0]              result_code,
    output logic [KEY_BITS-1:0]     result_key,
    output logic [OWNER_BITS-1:0]   result_owner,
    output logic                    last
);

    olt_pkg::rc_t                code_mem  [olt_pkg::QDEPTH];
    logic [KEY_BITS-1:0]         key_mem   [olt_pkg::QDEPTH];
    logic [OWNER_BITS-1:0]       owner_mem [olt_pkg::QDEPTH];
    logic                        last_mem  [olt_pkg::QDEPTH];

    logic [olt_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        wr_ptr_reg, rd_ptr_reg;
    logic                        push_ok, pop_ok;

    assign res_full = (count_reg == olt_pkg::QCNT_W'(olt_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = res_ctl.push && !res_full;
    assign pop_ok   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (!push_ok && pop_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_ok)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            code_mem[wr_ptr_reg]  <= res_ctl.code;
            key_mem[wr_ptr_reg]   <= res_key;
            owner_mem[wr_ptr_reg] <= res_owner;
            last_mem[wr_ptr_reg]  <= res_ctl.last;
        end
    end

    assign result_code  = code_mem[rd_ptr_reg];
    assign result_key   = key_mem[rd_ptr_reg];
    assign result_owner = owner_mem[rd_ptr_reg];
    assign last         = last_mem[rd_ptr_reg];

endmodule

[hdl/owned_lock_table.sv]
// Top level of the owned lock table: front end, back end and result queue.
// Depends on olt_pkg, olt_front, olt_back and olt_resq.
//
//  channel   handshake             payload
//  --------  --------------------  ----------------------------------------
//  items     push / full           opcode, lock_key, client_id
//  results   empty / pop           result_code, result_key, result_owner, last
//
// Request, release and inquire capture the lookup as the sequencer takes
// the item, then write one result, or two for a granted request or an
// owner's release. Unregister walks the slot table one slot a cycle,
// holding at an owned slot while the result queue is full, then writes
// the done item. Items wait in a two-entry queue at the front, results in
// a two-entry queue at the back; either side may stall without stopping
// the other until its queue fills. Reset (rst_n low, asynchronous) empties
// both queues and frees every slot; there is no clearing pass.
module owned_lock_table #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int OWNER_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic [KEY_BITS-1:0]     lock_key,
    input  logic [OWNER_BITS-1:0]   client_id,
    output logic                    empty,
    input  logic                    pop,
    output logic [2:0]              result_code,
    output logic [KEY_BITS-1:0]     result_key,
    output logic [OWNER_BITS-1:0]   result_owner,
    output logic                    last
);

    olt_pkg::front_ctl_t       head_ctl;
    logic [KEY_BITS-1:0]       head_key;
    logic [OWNER_BITS-1:0]     head_cid;
    logic                      head_pop;

    olt_pkg::res_ctl_t         res_ctl;
    logic [KEY_BITS-1:0]       res_key;
    logic [OWNER_BITS-1:0]     res_owner;
    logic                      res_full;

    // Item queue with opcode decode.
    olt_front #(
        .KEY_BITS   (KEY_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .lock_key  (lock_key),
        .client_id (client_id),
        .head_ctl  (head_ctl),
        .head_key  (head_key),
        .head_cid  (head_cid),
        .head_pop  (head_pop)
    );

    // Slot table and execution sequencer.
    olt_back #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_ctl  (head_ctl),
        .head_key  (head_key),
        .head_cid  (head_cid),
        .head_pop  (head_pop),
        .res_ctl   (res_ctl),
        .res_key   (res_key),
        .res_owner (res_owner),
        .res_full  (res_full)
    );

    // Result queue driving the result ports.
    olt_resq #(
        .KEY_BITS   (KEY_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_ctl      (res_ctl),
        .res_key      (res_key),
        .res_owner    (res_owner),
        .res_full     (res_full),
        .empty        (empty),
        .pop          (pop),
        .result_code  (result_code),
        .result_key   (result_key),
        .result_owner (result_owner),
        .last         (last)
    );

endmodule
